FILE: rtl/cel_pkg.sv
// Shared types and constants for the CSR edge lookup block.
// Holds table sizes, field widths and the kind codes; depends on nothing.
package cel_pkg;

	// Table sizes.
	localparam int MaxNodes = 1024;
	localparam int MaxEdges = 4096;

	// Word field widths.
	localparam int KIND_W   = 2;
	localparam int LADDR_W  = 12;
	localparam int LVAL_W   = 13;
	localparam int NODE_W   = 10;
	localparam int EIDX_W   = 12;
	localparam int NCOUNT_W = 11;

	// Derived memory geometry.
	localparam int OFF_AW = $clog2(MaxNodes + 1);
	localparam int OFF_W  = LVAL_W;
	localparam int TGT_AW = $clog2(MaxEdges);
	localparam int TGT_W  = NODE_W;
	localparam int EPTR_W = TGT_AW + 1;

	// Input word kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD_OFFSET = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_TARGET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd2;

	// Scan unit control and status.
	typedef struct packed {
		logic              start;
		logic [OFF_W-1:0]  first;
		logic [EPTR_W-1:0] last;
	} scan_ctl_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [EIDX_W-1:0] index;
	} scan_stat_t;

endpackage

FILE: rtl/cel_if.sv
// Valid/ready channel interfaces for the CSR edge lookup block.
// Field widths come from cel_pkg.
interface cel_req_if;
	import cel_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [LADDR_W-1:0]  load_address;
	logic [LVAL_W-1:0]   load_value;
	logic [NODE_W-1:0]   source_node;
	logic [NODE_W-1:0]   target_node;

	modport source (output valid, kind, load_address, load_value, source_node, target_node,
		input ready);
	modport sink (input valid, kind, load_address, load_value, source_node, target_node,
		output ready);
endinterface

interface cel_rsp_if;
	import cel_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [EIDX_W-1:0] edge_index;
	logic              source_out_of_range;

	modport source (output valid, found, edge_index, source_out_of_range, input ready);
	modport sink (input valid, found, edge_index, source_out_of_range, output ready);
endinterface

FILE: rtl/cel_ram.sv
// Generic single-write, single-read memory with registered read data.
// Stands alone; used for the offset and edge target tables.
module cel_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/cel_scan.sv
// Edge range scanner: walks one edge index per cycle and compares the
// stored target against the wanted node. Depends on cel_pkg.
module cel_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cel_pkg::scan_ctl_t            ctl,
	input  logic [cel_pkg::NODE_W-1:0]    dst,
	output logic                          rd_en,
	output logic [cel_pkg::TGT_AW-1:0]    rd_addr,
	input  logic [cel_pkg::TGT_W-1:0]     rd_data,
	output cel_pkg::scan_stat_t           stat
);
	import cel_pkg::*;

	logic              busy_q;
	logic [EPTR_W-1:0] ptr_q;
	logic [EPTR_W-1:0] last_q;
	logic              pend_s1;
	logic [EIDX_W-1:0] idx_s1;
	logic              issue;
	logic              hit;

	// Issue a read while edges remain; compare the one read last cycle.
	always_comb begin
		issue      = busy_q && (ptr_q < last_q);
		hit        = busy_q && pend_s1 && (rd_data == dst);
		rd_en      = issue;
		rd_addr    = ptr_q[TGT_AW-1:0];
		stat.done  = busy_q && (hit || (!issue && !pend_s1));
		stat.found = hit;
		stat.index = hit ? idx_s1 : '0;
	end

	// Sequencing of the scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			pend_s1 <= 1'b0;
		end else if (busy_q) begin
			busy_q  <= !stat.done;
			pend_s1 <= issue && !hit;
		end
	end

	// Pointer and index registers carry no reset.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ptr_q  <= EPTR_W'(ctl.first);
			last_q <= ctl.last;
		end else if (issue) begin
			ptr_q  <= ptr_q + 1'b1;
		end
		if (issue) begin
			idx_s1 <= ptr_q[EIDX_W-1:0];
		end
	end

	// A pending compare always belongs to an edge inside the range.
	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && pend_s1 |-> (EPTR_W'(idx_s1) < last_q))
		else $error("pending edge index outside scan range");

	// A finished scan releases the unit on the next cycle.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && !ctl.start |=> !busy_q)
		else $error("scan unit stayed busy after done");

	// A hit is only reported for an edge that was actually read.
	a_hit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		stat.found |-> $past(issue))
		else $error("hit without a preceding read");
endmodule

FILE: rtl/csr_edge_lookup_unit.sv
// CSR edge lookup: searches a source node's edge range for a destination node.
// Load words leave the block idle. A query in range passes through the begin, end,
// scan and post states; the scan reads one target per cycle from a single memory port
// and stops at the first matching edge or at the end of the range, which may be empty
// or inverted. An out-of-range query goes straight to the post state. A result still
// waiting in the output register stalls the post state. Reset clears node_count and
// all control state; the tables are not cleared.
module csr_edge_lookup_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [cel_pkg::NCOUNT_W-1:0]  cfg_wr_data,
	cel_req_if.sink                       req,
	cel_rsp_if.source                     rsp
);
	import cel_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BEGIN = 3'd1;
	localparam logic [2:0] S_END   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_POST  = 3'd4;

	logic [2:0]          state_q;
	logic [NCOUNT_W-1:0] node_count_q;
	logic [NODE_W-1:0]   src_q;
	logic [NODE_W-1:0]   dst_q;
	logic [OFF_W-1:0]    first_q;
	logic                res_found_q;
	logic [EIDX_W-1:0]   res_index_q;
	logic                res_oor_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [EIDX_W-1:0]   out_index_q;
	logic                out_oor_q;

	logic                accept;
	logic                is_query;
	logic                src_oor;
	logic                off_we;
	logic                tgt_we;
	logic                off_re;
	logic [OFF_AW-1:0]   off_raddr;
	logic [OFF_W-1:0]    off_rdata;
	logic [EPTR_W-1:0]   last_sat;
	logic                post_load;
	logic                tgt_re;
	logic [TGT_AW-1:0]   tgt_raddr;
	logic [TGT_W-1:0]    tgt_rdata;
	scan_ctl_t           scan_ctl;
	scan_stat_t          scan_stat;

	// Handshake and decode of the incoming word.
	always_comb begin
		req.ready = (state_q == S_IDLE);
		accept    = req.valid && req.ready;
		is_query  = accept && (req.kind == KIND_QUERY);
		src_oor   = (NCOUNT_W'(req.source_node) >= node_count_q) ||
			(NCOUNT_W'(req.source_node) >= NCOUNT_W'(MaxNodes));
		off_we    = accept && (req.kind == KIND_LOAD_OFFSET) &&
			(req.load_address <= LADDR_W'(MaxNodes));
		tgt_we    = accept && (req.kind == KIND_LOAD_TARGET) &&
			(EPTR_W'(req.load_address) < EPTR_W'(MaxEdges));
	end

	// Offset table reads: the range start at accept, the range end in the cycle after, in the begin state.
	always_comb begin
		off_re    = (is_query && !src_oor) || (state_q == S_BEGIN);
		off_raddr = (state_q == S_BEGIN) ? (OFF_AW'(src_q) + 1'b1)
			: OFF_AW'(req.source_node);
		last_sat  = (off_rdata > OFF_W'(MaxEdges)) ? EPTR_W'(MaxEdges)
			: EPTR_W'(off_rdata);
		scan_ctl.start = (state_q == S_END);
		scan_ctl.first = first_q;
		scan_ctl.last  = last_sat;
		post_load = (state_q == S_POST) && (!out_valid_q || rsp.ready);
	end

	cel_ram #(
		.DEPTH(MaxNodes + 1),
		.WIDTH(OFF_W)
	) u_offset_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (req.load_address[OFF_AW-1:0]),
		.wdata (req.load_value),
		.re    (off_re),
		.raddr (off_raddr),
		.rdata (off_rdata)
	);

	cel_ram #(
		.DEPTH(MaxEdges),
		.WIDTH(TGT_W)
	) u_target_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (req.load_address[TGT_AW-1:0]),
		.wdata (req.load_value[TGT_W-1:0]),
		.re    (tgt_re),
		.raddr (tgt_raddr),
		.rdata (tgt_rdata)
	);

	cel_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.dst     (dst_q),
		.rd_en   (tgt_re),
		.rd_addr (tgt_raddr),
		.rd_data (tgt_rdata),
		.stat    (scan_stat)
	);

	// Sequencer and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (is_query) begin
						state_q <= src_oor ? S_POST : S_BEGIN;
					end
				end
				S_BEGIN: state_q <= S_END;
				S_END:   state_q <= S_SCAN;
				S_SCAN: begin
					if (scan_stat.done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (post_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query operands and the pending result.
	always_ff @(posedge clk) begin
		if (is_query) begin
			src_q       <= req.source_node;
			dst_q       <= req.target_node;
			res_found_q <= 1'b0;
			res_index_q <= '0;
			res_oor_q   <= src_oor;
		end
		if (state_q == S_BEGIN) begin
			first_q <= off_rdata;
		end
		if (state_q == S_SCAN && scan_stat.done) begin
			res_found_q <= scan_stat.found;
			res_index_q <= scan_stat.index;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_load) begin
			out_found_q <= res_found_q;
			out_index_q <= res_index_q;
			out_oor_q   <= res_oor_q;
		end
	end

	assign rsp.valid               = out_valid_q;
	assign rsp.found               = out_found_q;
	assign rsp.edge_index          = out_index_q;
	assign rsp.source_out_of_range = out_oor_q;

	// An accepted query always leaves the idle state.
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		is_query |=> state_q != S_IDLE)
		else $error("query accepted but sequencer stayed idle");

	// The scan unit only finishes while the sequencer waits for it.
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.done |-> state_q == S_SCAN)
		else $error("scan done outside the scan state");

	// Leaving the post state always presents a result.
	a_post_emits: assert property (@(posedge clk) disable iff (!arst_n)
		post_load |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented after post state");

	// A flagged source never reports a match.
	a_oor_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		post_load && res_oor_q |-> !res_found_q && res_index_q == '0)
		else $error("out-of-range query carries a match");
endmodule

FILE: verif/tb_csr_edge_lookup_unit.sv
`timescale 1ns / 1ps
// Testbench for csr_edge_lookup_unit. It loads small graphs into the offset and target
// tables, queries them, and checks each result word against a local edge search.
// Depends on cel_pkg and on the cel_req_if and cel_rsp_if interfaces.
module tb_csr_edge_lookup_unit;
	import cel_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int MaxGap = 12;
	localparam int SettleCycles = 16;
	localparam int MaxScanLen = 128;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LADDR_W-1:0] load_address;
		logic [LVAL_W-1:0]  load_value;
		logic [NODE_W-1:0]  source_node;
		logic [NODE_W-1:0]  target_node;
	} lookup_req_t;

	typedef struct packed {
		logic              found;
		logic [EIDX_W-1:0] edge_index;
		logic              source_out_of_range;
	} lookup_res_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [NCOUNT_W-1:0] cfg_wr_data;

	cel_req_if req_ch();
	cel_rsp_if rsp_ch();

	csr_edge_lookup_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	// Words waiting for the sender and lookups waiting for their result word.
	lookup_req_t pending_words [$];
	lookup_res_t expected_lookups [$];
	int words_queued = 0;
	int words_taken = 0;
	int useful_words = 0;
	int error_count = 0;

	// Handshake flags seen at the last rising edge, and the idle state of both sides.
	bit req_fire = 1'b0;
	bit rsp_fire = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	// Table contents as the block should hold them, updated on accepted words.
	logic [OFF_W-1:0]    mirror_offsets [0:MaxNodes];
	logic [TGT_W-1:0]    mirror_targets [0:MaxEdges-1];
	logic [NCOUNT_W-1:0] mirror_node_count = '0;

	// Table contents as the stimulus has planned them, with a flag for each written entry.
	logic [OFF_W-1:0] plan_offsets [0:MaxNodes];
	logic [TGT_W-1:0] plan_targets [0:MaxEdges-1];
	bit               plan_off_set [0:MaxNodes];
	bit               plan_tgt_set [0:MaxEdges-1];
	int               plan_node_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Scans the source's edge range in order and returns the first edge that hits.
	function automatic lookup_res_t lookup_edge(input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst);
		lookup_res_t res;
		int node;
		int scan_lo;
		int scan_hi;
		res = '0;
		node = src;
		if (src >= mirror_node_count || node >= MaxNodes) begin
			res.source_out_of_range = 1'b1;
			return res;
		end
		scan_lo = mirror_offsets[node];
		scan_hi = mirror_offsets[node + 1];
		if (scan_hi > MaxEdges) begin
			scan_hi = MaxEdges;
		end
		for (int e = scan_lo; e < scan_hi; e++) begin
			if (mirror_targets[e] == dst) begin
				res.found = 1'b1;
				res.edge_index = e[EIDX_W-1:0];
				return res;
			end
		end
		return res;
	endfunction

	// Sampling at the rising edge: register writes, accepted words and result words.
	always @(posedge clk) begin
		lookup_res_t seen;
		lookup_res_t wanted;
		req_fire <= req_ch.valid && req_ch.ready;
		rsp_fire <= rsp_ch.valid && rsp_ch.ready;
		if (arst_n) begin
			if (cfg_wr_en) begin
				mirror_node_count = cfg_wr_data;
			end
			if (req_ch.valid && req_ch.ready) begin
				words_taken++;
				case (req_ch.kind)
					KIND_LOAD_OFFSET: begin
						if (req_ch.load_address <= MaxNodes) begin
							mirror_offsets[req_ch.load_address] = req_ch.load_value;
						end
					end
					KIND_LOAD_TARGET: begin
						if (req_ch.load_address < MaxEdges) begin
							mirror_targets[req_ch.load_address] = req_ch.load_value[TGT_W-1:0];
						end
					end
					KIND_QUERY: begin
						expected_lookups.push_back(
							lookup_edge(req_ch.source_node, req_ch.target_node));
					end
					default: begin
					end
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen = '{rsp_ch.found, rsp_ch.edge_index, rsp_ch.source_out_of_range};
				if (expected_lookups.size() == 0) begin
					report_mismatch("result word with no query waiting");
				end else begin
					wanted = expected_lookups.pop_front();
					if (seen.found !== wanted.found) begin
						report_mismatch($sformatf("found: got %0b expected %0b",
							seen.found, wanted.found));
					end
					if (seen.edge_index !== wanted.edge_index) begin
						report_mismatch($sformatf("edge_index: got %0d expected %0d",
							seen.edge_index, wanted.edge_index));
					end
					if (seen.source_out_of_range !== wanted.source_out_of_range) begin
						report_mismatch($sformatf("source_out_of_range: got %0b expected %0b",
							seen.source_out_of_range, wanted.source_out_of_range));
					end
				end
			end
		end
	end

	// The sender holds a word until it is taken, then idles for the gap drawn with it.
	always @(negedge clk) begin
		lookup_req_t w;
		if (arst_n) begin
			if (req_ch.valid && !req_fire) begin
				// Still waiting for the block to take the current word.
			end else if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap--;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= w.kind;
				req_ch.load_address <= w.load_address;
				req_ch.load_value <= w.load_value;
				req_ch.source_node <= w.source_node;
				req_ch.target_node <= w.target_node;
				if ($urandom_range(0, 39) == 0) begin
					send_burst = !send_burst;
				end
				send_gap = send_burst ? 0 : $urandom_range(0, MaxGap);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// The receiver withholds ready for a randomly drawn stall after each result word.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_fire) begin
				if ($urandom_range(0, 39) == 0) begin
					recv_burst = !recv_burst;
				end
				recv_stall = recv_burst ? 0 : $urandom_range(0, MaxGap);
			end
			if (recv_stall > 0) begin
				rsp_ch.ready <= 1'b0;
				recv_stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int any_addr();
		return $urandom_range(0, (1 << LADDR_W) - 1);
	endfunction

	function automatic int any_value();
		return $urandom_range(0, MaxEdges);
	endfunction

	function automatic int any_node();
		return $urandom_range(0, MaxNodes - 1);
	endfunction

	function automatic lookup_req_t make_word(input logic [KIND_W-1:0] kind, input int addr,
		input int val, input int src, input int dst);
		lookup_req_t w;
		w.kind = kind;
		w.load_address = addr[LADDR_W-1:0];
		w.load_value = val[LVAL_W-1:0];
		w.source_node = src[NODE_W-1:0];
		w.target_node = dst[NODE_W-1:0];
		return w;
	endfunction

	// Queues a word for the sender and tracks what it does to the planned tables.
	function automatic void enqueue_word(input lookup_req_t w);
		int addr;
		addr = w.load_address;
		pending_words.push_back(w);
		words_queued++;
		case (w.kind)
			KIND_LOAD_OFFSET: begin
				if (addr <= MaxNodes) begin
					plan_offsets[addr] = w.load_value;
					plan_off_set[addr] = 1'b1;
					useful_words++;
				end
			end
			KIND_LOAD_TARGET: begin
				plan_targets[addr] = w.load_value[TGT_W-1:0];
				plan_tgt_set[addr] = 1'b1;
				useful_words++;
			end
			KIND_QUERY: useful_words++;
			default: begin
			end
		endcase
	endfunction

	function automatic void put_word(input logic [KIND_W-1:0] kind, input int addr,
		input int val, input int src, input int dst);
		enqueue_word(make_word(kind, addr, val, src, dst));
	endfunction

	// A query is only sent when every table entry it may read has been written,
	// and its range is short enough to keep the scan time bounded.
	function automatic bit query_reads_written(input int src);
		int scan_lo;
		int scan_hi;
		if (src >= plan_node_count) begin
			return 1'b1;
		end
		if (!plan_off_set[src] || !plan_off_set[src + 1]) begin
			return 1'b0;
		end
		scan_lo = plan_offsets[src];
		scan_hi = plan_offsets[src + 1];
		if (scan_hi > MaxEdges) begin
			scan_hi = MaxEdges;
		end
		if (scan_hi - scan_lo > MaxScanLen) begin
			return 1'b0;
		end
		for (int e = scan_lo; e < scan_hi; e++) begin
			if (!plan_tgt_set[e]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic void ask_edge(input int src, input int dst);
		if (query_reads_written(src)) begin
			put_word(KIND_QUERY, any_addr(), any_value(), src, dst);
		end
	endfunction

	// Loads a few consecutive nodes with their edges in shuffled order, then queries them.
	// Targets come mostly from a small pool so that a range often holds repeats.
	function automatic void build_graph();
		int k;
		int n0;
		int e0;
		int total;
		int t;
		int lv;
		int pick;
		int nq;
		int deg [6];
		int offs [7];
		int pool [3];
		lookup_req_t loads [$];
		k = $urandom_range(1, 6);
		if (plan_node_count > k && $urandom_range(0, 4) != 0) begin
			n0 = $urandom_range(0, plan_node_count - k);
		end else begin
			n0 = $urandom_range(0, MaxNodes - k);
		end
		total = 0;
		for (int i = 0; i < k; i++) begin
			deg[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
			total += deg[i];
		end
		e0 = $urandom_range(0, MaxEdges - total);
		offs[0] = e0;
		for (int i = 0; i < k; i++) begin
			offs[i + 1] = offs[i] + deg[i];
		end
		// Now and then a node starts past the table, which inverts its range.
		if (k > 1 && $urandom_range(0, 7) == 0) begin
			offs[$urandom_range(1, k - 1)] = MaxEdges;
		end
		for (int i = 0; i < 3; i++) begin
			pool[i] = any_node();
		end
		for (int i = 0; i <= k; i++) begin
			loads.push_back(make_word(KIND_LOAD_OFFSET, n0 + i, offs[i], any_node(), any_node()));
		end
		for (int e = e0; e < e0 + total; e++) begin
			t = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 2)] : any_node();
			// Bits above the node width are dropped when the target is stored.
			lv = t + (1 << TGT_W) * $urandom_range(0, 3);
			if (t == 0 && $urandom_range(0, 1) == 0) begin
				lv = MaxEdges;
			end
			loads.push_back(make_word(KIND_LOAD_TARGET, e, lv, any_node(), any_node()));
		end
		while (loads.size() > 0) begin
			pick = $urandom_range(0, loads.size() - 1);
			enqueue_word(loads[pick]);
			loads.delete(pick);
		end
		nq = $urandom_range(2, 3 * k + 1);
		for (int i = 0; i < nq; i++) begin
			ask_edge(n0 + $urandom_range(0, k - 1),
				($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 2)] : any_node());
		end
	endfunction

	// Stray loads, unused kinds and queries on arbitrary sources.
	function automatic void add_noise();
		case ($urandom_range(0, 5))
			0: put_word(KIND_LOAD_OFFSET, any_addr(), any_value(), any_node(), any_node());
			1: put_word(KIND_LOAD_OFFSET, $urandom_range(0, MaxNodes), any_value(), any_node(),
				any_node());
			2: put_word(KIND_LOAD_TARGET, any_addr(), any_value(), any_node(), any_node());
			3: put_word(KIND_UNUSED, any_addr(), any_value(), any_node(), any_node());
			default: ask_edge(any_node(), any_node());
		endcase
	endfunction

	// Waits until every word is taken and every result is in, then lets loads settle.
	task automatic wait_idle();
		while (words_taken != words_queued || expected_lookups.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_node_count(input int value);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[NCOUNT_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		plan_node_count = value;
	endtask

	// Stimulus: reset, a directed part, then random phases under several node counts.
	initial begin
		int phase_words [6];
		int phase_nodes [6];
		int goal;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.load_address = '0;
		req_ch.load_value = '0;
		req_ch.source_node = '0;
		req_ch.target_node = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Top of both tables: the last node's range ends exactly at the table end.
		write_node_count(MaxNodes);
		put_word(KIND_LOAD_OFFSET, MaxNodes - 2, MaxEdges - 6, 0, MaxNodes - 1);
		put_word(KIND_LOAD_OFFSET, MaxNodes - 1, MaxEdges - 3, MaxNodes - 1, 0);
		put_word(KIND_LOAD_OFFSET, MaxNodes, MaxEdges, 0, 0);
		put_word(KIND_LOAD_TARGET, MaxEdges - 6, MaxEdges - 1, 0, 0);
		put_word(KIND_LOAD_TARGET, MaxEdges - 5, 0, MaxNodes - 1, MaxNodes - 1);
		put_word(KIND_LOAD_TARGET, MaxEdges - 4, 5, 0, 0);
		put_word(KIND_LOAD_TARGET, MaxEdges - 3, MaxNodes - 1, 0, 0);
		put_word(KIND_LOAD_TARGET, MaxEdges - 2, 7, 0, 0);
		put_word(KIND_LOAD_TARGET, MaxEdges - 1, MaxEdges, 0, 0);
		// Offset loads past the table and the unused kind change nothing.
		put_word(KIND_LOAD_OFFSET, MaxEdges - 1, 0, 0, 0);
		put_word(KIND_LOAD_OFFSET, MaxNodes + 1, 17, 0, 0);
		put_word(KIND_UNUSED, MaxEdges - 1, MaxEdges, MaxNodes - 1, MaxNodes - 1);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 2, MaxNodes - 1);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 1, 0);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 1, MaxNodes - 1);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 2, 7);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 2, 0);
		// Empty range on node 0, then an inverted range on node 1.
		put_word(KIND_LOAD_OFFSET, 0, 0, 0, 0);
		put_word(KIND_LOAD_OFFSET, 1, 0, 0, 0);
		put_word(KIND_QUERY, MaxEdges - 1, MaxEdges, 0, 0);
		put_word(KIND_LOAD_OFFSET, 2, 3, 0, 0);
		put_word(KIND_LOAD_OFFSET, 1, MaxEdges, 0, 0);
		put_word(KIND_QUERY, 0, 0, 1, 0);
		// Sources at and past the node count are flagged.
		write_node_count(1);
		put_word(KIND_QUERY, 0, 0, 1, 0);
		put_word(KIND_QUERY, 0, 0, MaxNodes - 1, MaxNodes - 1);

		phase_words = '{200, 40, 120, 200, 220, 220};
		phase_nodes = '{MaxNodes, 0, 1, MaxNodes - 1, $urandom_range(2, MaxNodes - 2), MaxNodes};
		goal = useful_words;
		for (int p = 0; p < 6; p++) begin
			// Each phase starts only once the block has drained.
			write_node_count(phase_nodes[p]);
			goal += phase_words[p];
			while (useful_words < goal) begin
				if ($urandom_range(0, 6) == 0) begin
					add_noise();
				end else begin
					build_graph();
				end
			end
		end

		wait_idle();
		if (error_count == 0) begin
			$display("PASS csr_edge_lookup_unit");
		end else begin
			$display("FAIL csr_edge_lookup_unit");
		end
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#3_000_000;
		$display("FAIL csr_edge_lookup_unit");
		$finish;
	end

endmodule
